/* rtl/core/tdq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tdq_pkg
// Shared sizes, task kinds, the task entry and the dispatch decision record.
// ----------------------------------------------------------------------------
package tdq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int STACK_DEPTH = 8;
    localparam int TAG_BITS    = 8;

    localparam int QA_W = $clog2(QUEUE_DEPTH);
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SA_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SC_W = $clog2(STACK_DEPTH + 1);

    localparam int IN_DATA_W  = ((TAG_BITS + 5 + 7) / 8) * 8;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = ((2 * TAG_BITS + 5 + QC_W + SC_W + 7) / 8) * 8;
    localparam int OUT_USER_W = 4;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_PRINT   = 2'd0;
    localparam t_kind KIND_ADD     = 2'd1;
    localparam t_kind KIND_HASH    = 2'd2;
    localparam t_kind KIND_UNKNOWN = 2'd3;

    typedef struct packed {
        t_kind               kind;
        logic [TAG_BITS-1:0] tag;
    } t_task;

    typedef struct packed {
        logic            sg_valid;
        logic            qg_valid;
        logic            defer;
        logic            overflow;
        logic            dropped;
        logic            enq;
        logic            deq;
        logic [SA_W-1:0] s_wr_idx;
        logic [SC_W-1:0] s_cnt_nxt;
        logic [QC_W-1:0] q_cnt_nxt;
    } t_dec;

    function automatic logic unit_free(t_kind k, logic [2:0] busy);
        case (k)
            KIND_PRINT: return !busy[0];
            KIND_ADD:   return !busy[1];
            KIND_HASH:  return !busy[2];
            default:    return 1'b0;
        endcase
    endfunction

    function automatic logic [2:0] unit_mask(t_kind k);
        case (k)
            KIND_PRINT: return 3'b001;
            KIND_ADD:   return 3'b010;
            KIND_HASH:  return 3'b100;
            default:    return 3'b000;
        endcase
    endfunction

endpackage
`default_nettype wire

/* rtl/core/tdq_decide.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tdq_decide
// One tick of dispatch: stack pop, queue grant or deferral, arrival append.
// ----------------------------------------------------------------------------
module tdq_decide (
    input  wire logic                     i_halt,
    input  wire logic [2:0]               i_busy,
    input  wire logic                     i_arrive_valid,
    input  wire tdq_pkg::t_task           i_top,
    input  wire logic [tdq_pkg::SC_W-1:0] i_s_cnt,
    input  wire tdq_pkg::t_task           i_head,
    input  wire logic [tdq_pkg::QC_W-1:0] i_q_cnt,
    output tdq_pkg::t_dec                 o_dec
);

    logic                     w_sg;
    logic                     w_qg;
    logic                     w_want_defer;
    logic                     w_defer;
    logic                     w_enq;
    logic [2:0]               w_busy_eff;
    logic [tdq_pkg::SC_W-1:0] w_s_cnt_pop;
    logic [tdq_pkg::QC_W-1:0] w_q_cnt_deq;

    always_comb begin
        w_sg = !i_halt && (i_s_cnt != '0) && tdq_pkg::unit_free(i_top.kind, i_busy);
        w_busy_eff = i_busy | (w_sg ? tdq_pkg::unit_mask(i_top.kind) : 3'b000);
        w_s_cnt_pop = i_s_cnt - tdq_pkg::SC_W'(w_sg);

        w_qg = !i_halt && (i_q_cnt != '0) && tdq_pkg::unit_free(i_head.kind, w_busy_eff);
        w_want_defer = !i_halt && (i_q_cnt != '0) && (i_head.kind != tdq_pkg::KIND_UNKNOWN)
                       && !w_qg;
        w_defer = w_want_defer && (w_s_cnt_pop < tdq_pkg::SC_W'(tdq_pkg::STACK_DEPTH));
        w_q_cnt_deq = i_q_cnt - tdq_pkg::QC_W'(w_qg || w_defer);

        w_enq = i_arrive_valid && (w_q_cnt_deq < tdq_pkg::QC_W'(tdq_pkg::QUEUE_DEPTH));

        o_dec.sg_valid  = w_sg;
        o_dec.qg_valid  = w_qg;
        o_dec.defer     = w_defer;
        o_dec.overflow  = w_want_defer && !w_defer;
        o_dec.dropped   = i_arrive_valid && !w_enq;
        o_dec.enq       = w_enq;
        o_dec.deq       = w_qg || w_defer;
        o_dec.s_wr_idx  = w_s_cnt_pop[tdq_pkg::SA_W-1:0];
        o_dec.s_cnt_nxt = w_s_cnt_pop + tdq_pkg::SC_W'(w_defer);
        o_dec.q_cnt_nxt = w_q_cnt_deq + tdq_pkg::QC_W'(w_enq);
    end

endmodule
`default_nettype wire

/* rtl/core/task_dispatcher_queue_stack.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// task_dispatcher_queue_stack
// Task dispatcher with a FIFO queue and a LIFO deferral stack in memories.
// ----------------------------------------------------------------------------
// result: the result register loads in S_EXEC, when the output is free or taken
// flow: no new item is taken until the last one leaves S_EXEC; the queue head and
//   stack top memories are read on accept, then updated and written back in S_EXEC
// reset: synchronous, clears pointers, counts, state and output valid;
//   memory contents are not cleared and no clearing pass runs
module task_dispatcher_queue_stack (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output      logic                           o_s_axis_tready,
    // arrive_valid, arrive_tag, print_unit_busy, add_unit_busy, hash_unit_busy, halt
    input  wire logic [tdq_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // arrive_kind
    input  wire logic [tdq_pkg::IN_USER_W-1:0]  i_s_axis_tuser,
    output      logic                           o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // stack_grant_valid, stack_grant_tag, queue_grant_valid, queue_grant_tag,
    // deferred, stack_overflow, arrival_dropped, queue_level, stack_level
    output      logic [tdq_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // stack_grant_kind, queue_grant_kind
    output      logic [tdq_pkg::OUT_USER_W-1:0] o_m_axis_tuser
);

    localparam int TB = tdq_pkg::TAG_BITS;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic [tdq_pkg::QA_W-1:0] r_q_head;
    logic [tdq_pkg::QA_W-1:0] r_q_tail;
    logic [tdq_pkg::QC_W-1:0] r_q_cnt;
    logic [tdq_pkg::SC_W-1:0] r_s_cnt;

    tdq_pkg::t_task r_q_mem [tdq_pkg::QUEUE_DEPTH];
    tdq_pkg::t_task r_s_mem [tdq_pkg::STACK_DEPTH];
    tdq_pkg::t_task r_q_rd;
    tdq_pkg::t_task r_s_rd;

    logic           r_arr_valid;
    tdq_pkg::t_task r_arr_task;
    logic [2:0]     r_busy;
    logic           r_halt;

    logic                           r_out_valid;
    logic [tdq_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [tdq_pkg::OUT_USER_W-1:0] r_out_user;

    logic                     w_accept;
    logic                     w_exec;
    logic [tdq_pkg::SC_W-1:0] w_s_top;
    tdq_pkg::t_dec            w_dec;
    tdq_pkg::t_kind           w_sg_kind;
    tdq_pkg::t_kind           w_qg_kind;
    logic [TB-1:0]            w_sg_tag;
    logic [TB-1:0]            w_qg_tag;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_exec          = (r_state == S_EXEC) && (!r_out_valid || i_m_axis_tready);
    assign w_s_top         = r_s_cnt - tdq_pkg::SC_W'(1);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_q_rd <= r_q_mem[r_q_head];
        end
        if (w_exec && w_dec.enq) begin
            r_q_mem[r_q_tail] <= r_arr_task;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s_rd <= r_s_mem[w_s_top[tdq_pkg::SA_W-1:0]];
        end
        if (w_exec && w_dec.defer) begin
            r_s_mem[w_dec.s_wr_idx] <= r_q_rd;
        end
    end

    tdq_decide u_decide (
        .i_halt         (r_halt),
        .i_busy         (r_busy),
        .i_arrive_valid (r_arr_valid),
        .i_top          (r_s_rd),
        .i_s_cnt        (r_s_cnt),
        .i_head         (r_q_rd),
        .i_q_cnt        (r_q_cnt),
        .o_dec          (w_dec)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_exec) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_sg_kind = w_dec.sg_valid ? r_s_rd.kind : tdq_pkg::KIND_PRINT;
        w_sg_tag  = w_dec.sg_valid ? r_s_rd.tag : '0;
        w_qg_kind = w_dec.qg_valid ? r_q_rd.kind : tdq_pkg::KIND_PRINT;
        w_qg_tag  = w_dec.qg_valid ? r_q_rd.tag : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_arr_valid     <= i_s_axis_tdata[0];
            r_arr_task.tag  <= i_s_axis_tdata[TB:1];
            r_arr_task.kind <= i_s_axis_tuser[1:0];
            r_busy          <= i_s_axis_tdata[TB+3:TB+1];
            r_halt          <= i_s_axis_tdata[TB+4];
        end
        if (w_exec) begin
            r_out_data <= tdq_pkg::OUT_DATA_W'({w_dec.s_cnt_nxt, w_dec.q_cnt_nxt,
                                                w_dec.dropped, w_dec.overflow, w_dec.defer,
                                                w_qg_tag, w_dec.qg_valid,
                                                w_sg_tag, w_dec.sg_valid});
            r_out_user <= {w_qg_kind, w_sg_kind};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_q_head    <= '0;
            r_q_tail    <= '0;
            r_q_cnt     <= '0;
            r_s_cnt     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_exec) begin
                r_out_valid <= 1'b1;
                r_q_cnt     <= w_dec.q_cnt_nxt;
                r_s_cnt     <= w_dec.s_cnt_nxt;
                if (w_dec.deq) begin
                    r_q_head <= (r_q_head == tdq_pkg::QA_W'(tdq_pkg::QUEUE_DEPTH - 1))
                                ? '0 : r_q_head + tdq_pkg::QA_W'(1);
                end
                if (w_dec.enq) begin
                    r_q_tail <= (r_q_tail == tdq_pkg::QA_W'(tdq_pkg::QUEUE_DEPTH - 1))
                                ? '0 : r_q_tail + tdq_pkg::QA_W'(1);
                end
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule
`default_nettype wire

/* rtl/core/tdq_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tdq_checker
// Port-level checks on the dispatcher input handshake and result stream, bound to the top level.
// ----------------------------------------------------------------------------
module tdq_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_s_axis_tvalid,
    input wire logic                           o_s_axis_tready,
    input wire logic                           o_m_axis_tvalid,
    input wire logic                           i_m_axis_tready,
    input wire logic [tdq_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input wire logic [tdq_pkg::OUT_USER_W-1:0] o_m_axis_tuser
);

    localparam int TB    = tdq_pkg::TAG_BITS;
    localparam int P_SGV = 0;
    localparam int P_QGV = TB + 1;
    localparam int P_DEF = 2 * TB + 2;
    localparam int P_OVF = 2 * TB + 3;
    localparam int P_QL  = 2 * TB + 5;
    localparam int P_SL  = P_QL + tdq_pkg::QC_W;

    logic [tdq_pkg::QC_W-1:0] w_q_lvl;
    logic [tdq_pkg::SC_W-1:0] w_s_lvl;

    assign w_q_lvl = o_m_axis_tdata[P_SL-1:P_QL];
    assign w_s_lvl = o_m_axis_tdata[P_SL+tdq_pkg::SC_W-1:P_SL];

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken again while an item is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            $countones({o_m_axis_tdata[P_QGV], o_m_axis_tdata[P_DEF],
                        o_m_axis_tdata[P_OVF]}) <= 1)
        else $error("queue head granted, deferred and overflowed together");

    a_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (w_q_lvl <= tdq_pkg::QC_W'(tdq_pkg::QUEUE_DEPTH)) &&
            (w_s_lvl <= tdq_pkg::SC_W'(tdq_pkg::STACK_DEPTH)))
        else $error("level beyond depth");

    a_unit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[P_SGV] && o_m_axis_tdata[P_QGV] |->
            o_m_axis_tuser[1:0] != o_m_axis_tuser[3:2])
        else $error("one unit granted twice in a tick");

endmodule

bind task_dispatcher_queue_stack tdq_checker u_tdq_checker (.*);
`default_nettype wire
